### rtl/mm4_pkg.sv
// Shared types for the fixed-point square matrix multiplier.
// Holds the load and result word layouts and the cell control struct.
// No dependencies.
`default_nettype none

package mm4_pkg;

	// One load word: element of A and element of B at the same position
	typedef struct packed {
		logic signed [31:0] a_element;
		logic signed [31:0] b_element;
	} load_word_t;

	// One result word: element of C, row-major, with end-of-matrix mark
	typedef struct packed {
		logic signed [31:0] product_element;
		logic               last_of_run;
	} result_word_t;

	// Control that travels down the cell chain beside each element index
	typedef struct packed {
		logic valid;
		logic last;
	} cell_ctl_t;

endpackage

`default_nettype wire

### rtl/mm4_cell.sv
// One multiply-accumulate cell of the matrix product chain.
// Cell k stores column k of A and row k of B; depends on mm4_pkg.
`default_nettype none

module mm4_cell #(
	parameter int ORDER    = 4,
	parameter int CELL_IDX = 0,
	parameter int SUM_W    = 66
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	// element index entering this cell
	input  mm4_pkg::cell_ctl_t         ctl_in,
	input  logic [$clog2(ORDER)-1:0]   row_in,
	input  logic [$clog2(ORDER)-1:0]   col_in,
	input  logic signed [SUM_W-1:0]    sum_in,
	// store write port
	input  logic                       wr_en,
	input  logic [$clog2(ORDER)-1:0]   wr_row,
	input  logic [$clog2(ORDER)-1:0]   wr_col,
	input  logic signed [31:0]         wr_a,
	input  logic signed [31:0]         wr_b,
	// handed to the next cell
	output mm4_pkg::cell_ctl_t         ctl_s1,
	output logic [$clog2(ORDER)-1:0]   row_s1,
	output logic [$clog2(ORDER)-1:0]   col_s1,
	output mm4_pkg::cell_ctl_t         ctl_s2,
	output logic signed [SUM_W-1:0]    sum_s2
);
	import mm4_pkg::*;

	localparam int RW = $clog2(ORDER);

	logic signed [31:0] a_col_q [ORDER];
	logic signed [31:0] b_row_q [ORDER];
	logic signed [63:0] prod_s1;

	// A[r][k] lands at index r, B[k][c] at index c
	always_ff @(posedge clk) begin
		if (wr_en && (wr_col == RW'(CELL_IDX))) begin
			a_col_q[wr_row] <= wr_a;
		end
		if (wr_en && (wr_row == RW'(CELL_IDX))) begin
			b_row_q[wr_col] <= wr_b;
		end
	end

	// stage 1: product A[i][k] * B[k][j]
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= a_col_q[row_in] * b_row_q[col_in];
			row_s1  <= row_in;
			col_s1  <= col_in;
		end
	end

	// stage 2: add to the partial sum from the previous cell
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum_in + SUM_W'(prod_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

endmodule

`default_nettype wire

### rtl/mm4_sat.sv
// Rounds a full-width dot product back to FRAC_BITS fraction bits and
// saturates it to 32 bits. Combinational; no dependencies.
`default_nettype none

module mm4_sat #(
	parameter int SUM_W     = 66,
	parameter int FRAC_BITS = 16
) (
	input  logic signed [SUM_W-1:0] sum,
	output logic signed [31:0]      result
);

	localparam logic signed [SUM_W-1:0] HALF    = (SUM_W'(1) << FRAC_BITS) >> 1;
	localparam logic signed [SUM_W-1:0] MAX_VAL = SUM_W'(64'sh7FFF_FFFF);
	localparam logic signed [SUM_W-1:0] MIN_VAL = -SUM_W'(64'sh8000_0000);

	logic signed [SUM_W-1:0] rounded;
	logic signed [SUM_W-1:0] scaled;

	// round half up, then arithmetic shift
	always_comb begin
		rounded = sum + HALF;
		scaled  = rounded >>> FRAC_BITS;
		priority if (scaled > MAX_VAL) begin
			result = 32'sh7FFF_FFFF;
		end else if (scaled < MIN_VAL) begin
			result = 32'sh8000_0000;
		end else begin
			result = scaled[31:0];
		end
	end

endmodule

`default_nettype wire

### rtl/matrix_4x4_multiply_core.sv
// Fixed-point square matrix multiplier C = A x B, Q(32-FRAC_BITS).FRAC_BITS.
// Load channel: one word per element pair (A and B at the same position),
// row-major, ORDER*ORDER words per matrix pair. Result channel: ORDER*ORDER
// words of C, row-major, last_of_run set on the final one.
// A chain of ORDER multiply-accumulate cells forms one dot product per
// cycle while the receiver does not stall; cell k owns column k of A and
// row k of B. Each element walks the chain, picking up one product per cell,
// then is rounded half up and saturated into the output register.
// Timing: loading accepts one word per cycle. After the final load word the
// block issues ORDER*ORDER element indices, one per cycle unless the
// receiver stalls; results then leave at one per cycle under the same
// condition. Loading of the next pair opens once the last cell has read its
// stores, and overlaps the drain of the remaining results.
// Reset empties the chain and the output register and restarts loading at
// element zero. When the receiver stalls, the whole chain holds in place.
`default_nettype none

module matrix_4x4_multiply_core #(
	parameter int ORDER     = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_valid,
	output logic                  load_ready,
	input  mm4_pkg::load_word_t   load_word,
	output logic                  result_valid,
	input  logic                  result_ready,
	output mm4_pkg::result_word_t result_word
);
	import mm4_pkg::*;

	localparam int RW    = $clog2(ORDER);
	localparam int SUM_W = 64 + $clog2(ORDER);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	localparam logic [RW-1:0] LAST_IDX = RW'(ORDER - 1);

	logic [1:0]    state_q, state_d;
	logic [RW-1:0] ld_row_q, ld_col_q;
	logic [RW-1:0] is_row_q, is_col_q;
	logic          load_fire, ld_last, is_last, adv, reads_done;

	cell_ctl_t               ctl_ch [ORDER+1];
	logic [RW-1:0]           row_ch [ORDER+1];
	logic [RW-1:0]           col_ch [ORDER+1];
	cell_ctl_t               ctl2_ch [ORDER];
	logic signed [SUM_W-1:0] sum_ch [ORDER];
	logic signed [31:0]      sat_res;

	logic         out_valid_q;
	result_word_t out_word_q;

	assign load_ready   = (state_q == ST_LOAD);
	assign load_fire    = load_valid && load_ready;
	assign ld_last      = (ld_row_q == LAST_IDX) && (ld_col_q == LAST_IDX);
	assign is_last      = (is_row_q == LAST_IDX) && (is_col_q == LAST_IDX);
	assign adv          = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign result_word  = out_word_q;

	// last index captured by the tail cell: all store reads are done
	assign reads_done = adv && ctl_ch[ORDER-1].valid && ctl_ch[ORDER-1].last;

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (load_fire && ld_last) state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (adv && is_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (reads_done) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// load position, row-major
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_row_q <= '0;
			ld_col_q <= '0;
		end else if (load_fire) begin
			if (ld_col_q == LAST_IDX) begin
				ld_col_q <= '0;
				ld_row_q <= (ld_row_q == LAST_IDX) ? '0 : ld_row_q + RW'(1);
			end else begin
				ld_col_q <= ld_col_q + RW'(1);
			end
		end
	end

	// issue position, row-major
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_row_q <= '0;
			is_col_q <= '0;
		end else if (adv && (state_q == ST_ISSUE)) begin
			if (is_col_q == LAST_IDX) begin
				is_col_q <= '0;
				is_row_q <= (is_row_q == LAST_IDX) ? '0 : is_row_q + RW'(1);
			end else begin
				is_col_q <= is_col_q + RW'(1);
			end
		end
	end

	// head of the chain
	assign ctl_ch[0].valid = (state_q == ST_ISSUE);
	assign ctl_ch[0].last  = is_last;
	assign row_ch[0]       = is_row_q;
	assign col_ch[0]       = is_col_q;

	// MAC cell chain
	for (genvar k = 0; k < ORDER; k++) begin : g_cell
		logic signed [SUM_W-1:0] sum_in;
		if (k == 0) begin : g_head
			assign sum_in = '0;
		end else begin : g_body
			assign sum_in = sum_ch[k-1];
		end

		mm4_cell #(
			.ORDER   (ORDER),
			.CELL_IDX(k),
			.SUM_W   (SUM_W)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.ctl_in(ctl_ch[k]),
			.row_in(row_ch[k]),
			.col_in(col_ch[k]),
			.sum_in(sum_in),
			.wr_en (load_fire),
			.wr_row(ld_row_q),
			.wr_col(ld_col_q),
			.wr_a  (load_word.a_element),
			.wr_b  (load_word.b_element),
			.ctl_s1(ctl_ch[k+1]),
			.row_s1(row_ch[k+1]),
			.col_s1(col_ch[k+1]),
			.ctl_s2(ctl2_ch[k]),
			.sum_s2(sum_ch[k])
		);
	end

	// round and saturate the finished dot product
	mm4_sat #(
		.SUM_W    (SUM_W),
		.FRAC_BITS(FRAC_BITS)
	) u_sat (
		.sum   (sum_ch[ORDER-1]),
		.result(sat_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl2_ch[ORDER-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl2_ch[ORDER-1].valid) begin
			out_word_q.product_element <= sat_res;
			out_word_q.last_of_run     <= ctl2_ch[ORDER-1].last;
		end
	end

endmodule

`default_nettype wire
